// ----- rtl/core/rcppm_pkg.sv -----
// rcppm_pkg: shared types, register indexes and constants for the RC PPM
// frame generator. No dependencies; every file in rtl/core refers to it.
`timescale 1ns / 1ps

package rcppm_pkg;

  localparam int unsigned MaxChannels = 10;
  // gap, two segments per channel, final sync, pad
  localparam int unsigned NumSegs     = 2 * MaxChannels + 3;
  localparam int unsigned SegW        = $clog2(NumSegs + 1);
  localparam int unsigned ChIdxW      = $clog2(MaxChannels);
  localparam int unsigned ElapsedW    = 20;
  localparam int unsigned AddrW       = 5;

  typedef logic [15:0] width_t;

  localparam width_t CenterWidth = 16'd1500;

  localparam logic ActionTick       = 1'b0;
  localparam logic ActionSetChannel = 1'b1;

  localparam logic [2:0] RegChannelCount = 3'd0;
  localparam logic [2:0] RegSyncWidth    = 3'd1;
  localparam logic [2:0] RegFrameLength  = 3'd2;
  localparam logic [2:0] RegMinFrameGap  = 3'd3;
  localparam logic [2:0] RegInvertOutput = 3'd4;
  localparam logic [2:0] RegMinValue     = 3'd5;
  localparam logic [2:0] RegMaxValue     = 3'd6;

  typedef struct packed {
    logic        action;
    logic [3:0]  channel;
    width_t      width_value;
  } in_req_t;

  typedef struct packed {
    logic ppm_level;
    logic frame_start;
    logic write_accepted;
  } out_rsp_t;

  typedef struct packed {
    logic [3:0] channel_count;
    width_t     sync_width;
    width_t     frame_length;
    width_t     min_frame_gap;
    logic       invert_output;
    width_t     min_value;
    width_t     max_value;
  } cfg_t;

endpackage

// ----- rtl/core/rcppm_cfg_regs.sv -----
// rcppm_cfg_regs: APB-style configuration register file.
// Depends on rcppm_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module rcppm_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcppm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rcppm_pkg::cfg_t             cfg_o
);

  rcppm_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rcppm_pkg::AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        rcppm_pkg::RegChannelCount: cfg_d.channel_count = pwdata[3:0];
        rcppm_pkg::RegSyncWidth:    cfg_d.sync_width    = pwdata[15:0];
        rcppm_pkg::RegFrameLength:  cfg_d.frame_length  = pwdata[15:0];
        rcppm_pkg::RegMinFrameGap:  cfg_d.min_frame_gap = pwdata[15:0];
        rcppm_pkg::RegInvertOutput: cfg_d.invert_output = pwdata[0];
        rcppm_pkg::RegMinValue:     cfg_d.min_value     = pwdata[15:0];
        rcppm_pkg::RegMaxValue:     cfg_d.max_value     = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcppm_pkg::RegChannelCount: prdata = {28'd0, cfg_q.channel_count};
      rcppm_pkg::RegSyncWidth:    prdata = {16'd0, cfg_q.sync_width};
      rcppm_pkg::RegFrameLength:  prdata = {16'd0, cfg_q.frame_length};
      rcppm_pkg::RegMinFrameGap:  prdata = {16'd0, cfg_q.min_frame_gap};
      rcppm_pkg::RegInvertOutput: prdata = {31'd0, cfg_q.invert_output};
      rcppm_pkg::RegMinValue:     prdata = {16'd0, cfg_q.min_value};
      rcppm_pkg::RegMaxValue:     prdata = {16'd0, cfg_q.max_value};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= 4'd8;
      cfg_q.sync_width    <= 16'd300;
      cfg_q.frame_length  <= 16'd22500;
      cfg_q.min_frame_gap <= 16'd4000;
      cfg_q.invert_output <= 1'b0;
      cfg_q.min_value     <= 16'd1000;
      cfg_q.max_value     <= 16'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/rcppm_seg_pick.sv -----
// rcppm_seg_pick: finds the first frame segment of nonzero length at or after
// a start index and returns its index and length. Depends on rcppm_pkg.
`timescale 1ns / 1ps

module rcppm_seg_pick (
  input  rcppm_pkg::width_t [rcppm_pkg::MaxChannels-1:0] widths_i,
  input  logic [3:0]                                     count_i,
  input  logic [rcppm_pkg::SegW-1:0]                     start_i,
  input  rcppm_pkg::width_t                              gap_i,
  input  rcppm_pkg::width_t                              sync_i,
  input  rcppm_pkg::width_t                              pad_len_i,
  input  logic                                           pad_nz_i,
  output logic                                           found_o,
  output logic [rcppm_pkg::SegW-1:0]                     seg_o,
  output rcppm_pkg::width_t                              len_o
);

  localparam int unsigned SegW   = rcppm_pkg::SegW;
  localparam int unsigned ChIdxW = rcppm_pkg::ChIdxW;

  logic [SegW-1:0]                     last_seg;
  logic [SegW-1:0]                     seg_m2;
  logic                                sync_nz;
  logic [rcppm_pkg::MaxChannels-1:0]   ch_nz;
  logic [rcppm_pkg::NumSegs-1:0]       nz;
  logic [rcppm_pkg::NumSegs-1:0]       cand;
  logic [ChIdxW-1:0]                   ch_sel;
  rcppm_pkg::width_t                   w_sel;

  // pad segment sits right after the final sync
  assign last_seg = {count_i, 1'b0} + SegW'(2);
  assign sync_nz  = |sync_i;

  for (genvar c = 0; c < rcppm_pkg::MaxChannels; c++) begin : g_ch
    assign ch_nz[c] = widths_i[c] > sync_i;
  end

  for (genvar j = 0; j < rcppm_pkg::NumSegs; j++) begin : g_seg
    if (j == 0) begin : g_gap
      assign nz[j] = |gap_i;
    end else if (j % 2 == 1) begin : g_sync
      assign nz[j] = sync_nz && (SegW'(j) < last_seg);
    end else if ((j - 2) / 2 < rcppm_pkg::MaxChannels) begin : g_idle
      assign nz[j] = (SegW'(j) == last_seg) ? pad_nz_i
                                            : (ch_nz[(j - 2) / 2] && (SegW'(j) < last_seg));
    end else begin : g_pad
      assign nz[j] = (SegW'(j) == last_seg) && pad_nz_i;
    end
    assign cand[j] = nz[j] && (SegW'(j) >= start_i);
  end

  // lowest candidate wins
  always_comb begin
    seg_o = '0;
    for (int j = rcppm_pkg::NumSegs - 1; j >= 0; j--) begin
      if (cand[j]) begin
        seg_o = SegW'(j);
      end
    end
  end

  assign found_o = |cand;
  assign seg_m2  = seg_o - SegW'(2);
  assign ch_sel  = ChIdxW'(seg_m2 >> 1);
  assign w_sel   = (ch_sel < ChIdxW'(rcppm_pkg::MaxChannels)) ? widths_i[ch_sel] : '0;

  always_comb begin
    if (seg_o == '0) begin
      len_o = gap_i;
    end else if (seg_o[0]) begin
      len_o = sync_i;
    end else if (seg_o == last_seg) begin
      len_o = pad_len_i;
    end else begin
      len_o = w_sel - sync_i;
    end
  end

endmodule

// ----- rtl/core/rcppm_engine.sv -----
// rcppm_engine: frame state, staged and active channel widths, and the
// per-request update. Depends on rcppm_pkg and rcppm_seg_pick.
`timescale 1ns / 1ps

module rcppm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  rcppm_pkg::in_req_t  req_i,
  input  rcppm_pkg::cfg_t     cfg_i,
  output rcppm_pkg::out_rsp_t rsp_o
);

  localparam int unsigned SegW     = rcppm_pkg::SegW;
  localparam int unsigned ElapsedW = rcppm_pkg::ElapsedW;

  rcppm_pkg::width_t [rcppm_pkg::MaxChannels-1:0] staged_q, staged_d;
  rcppm_pkg::width_t [rcppm_pkg::MaxChannels-1:0] active_q, active_d;
  logic [SegW-1:0]     seg_idx_q, seg_idx_d;
  rcppm_pkg::width_t   ticks_q, ticks_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                level_q, level_d;

  logic [3:0]          n_eff;
  logic [SegW-1:0]     last_seg;
  logic                idle_lvl;
  logic                pad_nz_a;
  rcppm_pkg::width_t   pad_len_a;
  logic                a_found, b_found;
  logic [SegW-1:0]     a_seg, b_seg;
  rcppm_pkg::width_t   a_len, b_len;
  logic                use_a;
  logic                wr_ok;

  assign n_eff    = (cfg_i.channel_count > 4'(rcppm_pkg::MaxChannels))
                  ? 4'(rcppm_pkg::MaxChannels) : cfg_i.channel_count;
  assign last_seg = {n_eff, 1'b0} + SegW'(2);
  assign idle_lvl = cfg_i.invert_output;

  assign pad_nz_a  = ElapsedW'(cfg_i.frame_length) > elapsed_q;
  assign pad_len_a = cfg_i.frame_length - elapsed_q[15:0];

  // continue the current frame
  rcppm_seg_pick u_pick_cur (
    .widths_i  (active_q),
    .count_i   (n_eff),
    .start_i   (seg_idx_q),
    .gap_i     (cfg_i.min_frame_gap),
    .sync_i    (cfg_i.sync_width),
    .pad_len_i (pad_len_a),
    .pad_nz_i  (pad_nz_a),
    .found_o   (a_found),
    .seg_o     (a_seg),
    .len_o     (a_len)
  );

  // open a fresh frame from the staged widths
  rcppm_seg_pick u_pick_new (
    .widths_i  (staged_q),
    .count_i   (n_eff),
    .start_i   ('0),
    .gap_i     (cfg_i.min_frame_gap),
    .sync_i    (cfg_i.sync_width),
    .pad_len_i (cfg_i.frame_length),
    .pad_nz_i  (|cfg_i.frame_length),
    .found_o   (b_found),
    .seg_o     (b_seg),
    .len_o     (b_len)
  );

  assign use_a       = (seg_idx_q != '0) && (seg_idx_q <= last_seg) && a_found;
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + ElapsedW'(1);
  assign wr_ok       = (req_i.channel < n_eff) && (req_i.width_value >= cfg_i.min_value)
                    && (req_i.width_value <= cfg_i.max_value);

  always_comb begin
    staged_d  = staged_q;
    active_d  = active_q;
    seg_idx_d = seg_idx_q;
    ticks_d   = ticks_q;
    elapsed_d = elapsed_q;
    level_d   = level_q;
    rsp_o     = '0;

    if (req_i.action == rcppm_pkg::ActionSetChannel) begin
      if (wr_ok) begin
        staged_d[req_i.channel[rcppm_pkg::ChIdxW-1:0]] = req_i.width_value;
      end
      rsp_o.write_accepted = wr_ok;
    end else if (ticks_q != '0) begin
      ticks_d   = ticks_q - 16'd1;
      elapsed_d = elapsed_inc;
    end else if (use_a) begin
      ticks_d   = a_len - 16'd1;
      seg_idx_d = a_seg + SegW'(1);
      level_d   = idle_lvl ^ a_seg[0];
      elapsed_d = elapsed_inc;
    end else begin
      rsp_o.frame_start = 1'b1;
      active_d          = staged_q;
      if (b_found) begin
        ticks_d   = b_len - 16'd1;
        seg_idx_d = b_seg + SegW'(1);
        level_d   = idle_lvl ^ b_seg[0];
        elapsed_d = ElapsedW'(1);
      end else begin
        // every segment is empty: hold idle and retry next tick
        ticks_d   = '0;
        seg_idx_d = '0;
        level_d   = idle_lvl;
        elapsed_d = '0;
      end
    end
    rsp_o.ppm_level = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q  <= {rcppm_pkg::MaxChannels{rcppm_pkg::CenterWidth}};
      active_q  <= {rcppm_pkg::MaxChannels{rcppm_pkg::CenterWidth}};
      seg_idx_q <= '0;
      ticks_q   <= '0;
      elapsed_q <= '0;
      level_q   <= 1'b0;
    end else if (fire_i) begin
      staged_q  <= staged_d;
      active_q  <= active_d;
      seg_idx_q <= seg_idx_d;
      ticks_q   <= ticks_d;
      elapsed_q <= elapsed_d;
      level_q   <= level_d;
    end
  end

endmodule

// ----- rtl/core/rc_ppm_frame_generator.sv -----
// rc_ppm_frame_generator: top level with request/result registers, the frame
// engine and the configuration port. Depends on rcppm_pkg and the rcppm_* modules.
`timescale 1ns / 1ps

// RC PPM pulse-train encoder. Each request is either one timing tick or a
// channel-width write; each gives exactly one result with the pin level, a
// frame-start flag and a write-accepted flag. The block takes one request per
// clock cycle at full rate while results are taken; an untaken result keeps the
// next request waiting in the request register. A request passes through the
// request register, then the result register, which holds its result until
// taken. Zero-length segments are skipped per request by a parallel segment
// search over the whole frame. No clearing pass runs after reset.
// Configuration registers sit on the APB port at byte address 4 * index and
// should be written only while no request is in flight.
module rc_ppm_frame_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rcppm_pkg::in_req_t          in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rcppm_pkg::out_rsp_t         out_rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcppm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rcppm_pkg::cfg_t     cfg;
  rcppm_pkg::in_req_t  in_q;
  logic                in_valid_q;
  rcppm_pkg::out_rsp_t out_q, rsp;
  logic                out_valid_q;
  logic                fire;

  // process the held request when the result register is free or draining
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  rcppm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcppm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    if (fire) begin
      out_q <= rsp;
    end
  end

endmodule

// ----- rtl/core/rcppm_checker.sv -----
// rcppm_checker: port-level assertions for rc_ppm_frame_generator, bound to
// the top level. Depends on rcppm_pkg.
`timescale 1ns / 1ps

module rcppm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input rcppm_pkg::out_rsp_t         out_rsp_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [rcppm_pkg::AddrW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);

  // a write result never reports a frame start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.write_accepted && out_rsp_o.frame_start))
    else $error("write result flagged as frame start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // a rising result valid traces back to an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a matching request");

  // an empty result register never blocks requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked while result register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == {rcppm_pkg::RegSyncWidth, 2'b00})
    ##1 (psel && !pwrite && paddr == {rcppm_pkg::RegSyncWidth, 2'b00})
    |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("sync width readback mismatch");

endmodule

bind rc_ppm_frame_generator rcppm_checker u_checker (.*);

// ----- dv/tb.sv -----
// tb: self-checking testbench for rc_ppm_frame_generator. Drives tick and
// set-channel requests, programs the APB registers and scores every result.
// Depends on rcppm_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned ElapsedMax  = (1 << rcppm_pkg::ElapsedW) - 1;

  typedef struct {
    bit                  is_cfg;
    logic [2:0]          reg_idx;
    rcppm_pkg::width_t   reg_val;
    rcppm_pkg::in_req_t  req;
    bit                  typed;
    rcppm_pkg::out_rsp_t rsp;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  rcppm_pkg::in_req_t            in_req_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  rcppm_pkg::out_rsp_t           out_rsp_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rcppm_pkg::AddrW-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // predictor copy of the block's registers and state
  rcppm_pkg::cfg_t               cfg_m;
  rcppm_pkg::width_t             staged_w [16];
  rcppm_pkg::width_t             active_w [16];
  int unsigned                   seg_idx;
  int unsigned                   ticks_left;
  int unsigned                   frame_ticks;
  logic                          pin_level;

  stim_row_t                     stim_rows [$];
  stim_row_t                     typed_rsp_q [$];
  rcppm_pkg::out_rsp_t           pending_rsp [$];
  int unsigned                   n_sent;
  int unsigned                   n_got;
  int unsigned                   n_err;
  bit                            quiet;

  rc_ppm_frame_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the pulse-train model by one request and return its result.
  function automatic rcppm_pkg::out_rsp_t predict_ppm(rcppm_pkg::in_req_t r);
    int unsigned         n;
    int unsigned         seg_k;
    int unsigned         w;
    int unsigned         sw;
    int                  iter;
    bit                  fs;
    bit                  acc;
    bit                  empty;
    logic                idle_lvl;
    rcppm_pkg::out_rsp_t rsp;
    n        = (32'(cfg_m.channel_count) > rcppm_pkg::MaxChannels) ?
               rcppm_pkg::MaxChannels : 32'(cfg_m.channel_count);
    sw       = 32'(cfg_m.sync_width);
    fs       = 1'b0;
    acc      = 1'b0;
    empty    = 1'b0;
    idle_lvl = cfg_m.invert_output;
    if (r.action == rcppm_pkg::ActionSetChannel) begin
      if (32'(r.channel) < n && r.width_value >= cfg_m.min_value &&
          r.width_value <= cfg_m.max_value) begin
        staged_w[r.channel] = r.width_value;
        acc = 1'b1;
      end
    end else begin
      iter = 0;
      while (iter < 40 && ticks_left == 0 && !empty) begin
        if (seg_idx == 0 || seg_idx > 2 * n + 2) begin
          // a second frame start within one tick means nothing has length
          if (fs) begin
            empty = 1'b1;
          end else begin
            active_w    = staged_w;
            fs          = 1'b1;
            frame_ticks = 0;
            seg_idx     = 0;
          end
        end
        if (!empty) begin
          if (seg_idx == 0) begin
            ticks_left = 32'(cfg_m.min_frame_gap);
            pin_level  = idle_lvl;
          end else if (seg_idx <= 2 * n) begin
            seg_k = seg_idx - 1;
            if (seg_k % 2 == 0) begin
              ticks_left = sw;
              pin_level  = ~idle_lvl;
            end else begin
              w          = 32'(active_w[seg_k / 2]);
              ticks_left = (w > sw) ? w - sw : 0;
              pin_level  = idle_lvl;
            end
          end else if (seg_idx == 2 * n + 1) begin
            ticks_left = sw;
            pin_level  = ~idle_lvl;
          end else begin
            ticks_left = (32'(cfg_m.frame_length) > frame_ticks) ?
                         32'(cfg_m.frame_length) - frame_ticks : 0;
            pin_level  = idle_lvl;
          end
          seg_idx++;
        end
        iter++;
      end
      if (ticks_left > 0 && !empty) begin
        ticks_left--;
        if (frame_ticks < ElapsedMax) frame_ticks++;
      end else begin
        ticks_left = 0;
        seg_idx    = 0;
        pin_level  = idle_lvl;
      end
    end
    rsp.ppm_level      = pin_level;
    rsp.frame_start    = fs;
    rsp.write_accepted = acc;
    return rsp;
  endfunction

  function automatic void row_cfg(logic [2:0] idx, rcppm_pkg::width_t v);
    stim_row_t d;
    d         = '{default: '0};
    d.is_cfg  = 1'b1;
    d.reg_idx = idx;
    d.reg_val = v;
    stim_rows.push_back(d);
  endfunction

  // rsp bits are {ppm_level, frame_start, write_accepted}
  function automatic void row_req(logic act, logic [3:0] ch, rcppm_pkg::width_t v,
                                  bit typed, rcppm_pkg::out_rsp_t rsp);
    stim_row_t d;
    d                   = '{default: '0};
    d.req.action        = act;
    d.req.channel       = ch;
    d.req.width_value   = v;
    d.typed             = typed;
    d.rsp               = rsp;
    stim_rows.push_back(d);
  endfunction

  function automatic void check_bit(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      $error("mismatch on %s: expected %0b, got %0b", name, exp_v, act_v);
      n_err++;
    end
  endfunction

  task automatic cfg_write(logic [2:0] idx, rcppm_pkg::width_t v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rcppm_pkg::RegChannelCount: cfg_m.channel_count = v[3:0];
      rcppm_pkg::RegSyncWidth:    cfg_m.sync_width    = v;
      rcppm_pkg::RegFrameLength:  cfg_m.frame_length  = v;
      rcppm_pkg::RegMinFrameGap:  cfg_m.min_frame_gap = v;
      rcppm_pkg::RegInvertOutput: cfg_m.invert_output = v[0];
      rcppm_pkg::RegMinValue:     cfg_m.min_value     = v;
      rcppm_pkg::RegMaxValue:     cfg_m.max_value     = v;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_req(rcppm_pkg::in_req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // Drop valid and hold until every request has its result back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (n_got < n_sent) @(posedge clk_i);
  endtask

  // Scoreboard: queue a prediction per accepted request, match each result.
  always @(posedge clk_i) begin : scoreboard
    rcppm_pkg::out_rsp_t e;
    rcppm_pkg::out_rsp_t p;
    stim_row_t           t;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_rsp.size() == 0) begin
          $error("result %b with no request pending", out_rsp_o);
          n_err++;
        end else begin
          e = pending_rsp.pop_front();
          check_bit("ppm_level", e.ppm_level, out_rsp_o.ppm_level);
          check_bit("frame_start", e.frame_start, out_rsp_o.frame_start);
          check_bit("write_accepted", e.write_accepted, out_rsp_o.write_accepted);
        end
        n_got++;
      end
      if (in_valid_i && in_ready_o) begin
        p = predict_ppm(in_req_i);
        if (typed_rsp_q.size() > 0) begin
          t = typed_rsp_q.pop_front();
          pending_rsp.push_back(t.typed ? t.rsp : p);
        end else begin
          pending_rsp.push_back(p);
        end
      end
    end
  end

  // Result side: random stalls plus one long hold-off to back up the block.
  initial begin : receiver
    int unsigned gap_left;
    int unsigned hold_left;
    bit          hold_done;
    gap_left    = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && n_got >= 300) begin
        hold_done   = 1'b1;
        hold_left   = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap_left    = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rcppm_pkg::cfg_t    s;
    rcppm_pkg::in_req_t r;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    n_sent     = 0;
    n_got      = 0;
    n_err      = 0;
    quiet      = 1'b0;
    cfg_m      = '{channel_count: 4'd8, sync_width: 16'd300, frame_length: 16'd22500,
                   min_frame_gap: 16'd4000, invert_output: 1'b0,
                   min_value: 16'd1000, max_value: 16'd2000};
    for (int i = 0; i < 16; i++) begin
      staged_w[i] = rcppm_pkg::CenterWidth;
      active_w[i] = rcppm_pkg::CenterWidth;
    end
    seg_idx     = 0;
    ticks_left  = 0;
    frame_ticks = 0;
    pin_level   = 1'b0;

    // empty frame: every segment zero, so each tick restarts the frame at idle
    row_cfg(rcppm_pkg::RegMinFrameGap, 16'd0);
    row_cfg(rcppm_pkg::RegSyncWidth, 16'd0);
    row_cfg(rcppm_pkg::RegFrameLength, 16'd0);
    row_cfg(rcppm_pkg::RegChannelCount, 16'd0);
    row_req(rcppm_pkg::ActionTick, 4'd0, 16'd0, 1'b1, 3'b010);
    row_req(rcppm_pkg::ActionTick, 4'd15, 16'hFFFF, 1'b1, 3'b010);
    row_cfg(rcppm_pkg::RegInvertOutput, 16'd1);
    row_req(rcppm_pkg::ActionTick, 4'd0, 16'd0, 1'b1, 3'b110);
    // count above ten, inverted window: nothing gets stored; with the window open, channel 9 is stored and 10 is not
    row_cfg(rcppm_pkg::RegChannelCount, 16'd15);
    row_cfg(rcppm_pkg::RegSyncWidth, 16'd2);
    row_cfg(rcppm_pkg::RegMinFrameGap, 16'd1);
    row_cfg(rcppm_pkg::RegMinValue, 16'd5);
    row_cfg(rcppm_pkg::RegMaxValue, 16'd3);
    row_req(rcppm_pkg::ActionSetChannel, 4'd0, 16'd4, 1'b1, 3'b100);
    row_cfg(rcppm_pkg::RegMinValue, 16'd0);
    row_cfg(rcppm_pkg::RegMaxValue, 16'hFFFF);
    row_req(rcppm_pkg::ActionSetChannel, 4'd9, 16'hFFFF, 1'b1, 3'b101);
    row_req(rcppm_pkg::ActionSetChannel, 4'd10, 16'd1, 1'b1, 3'b100);
    // zero width and width equal to sync: the idle part of the slot vanishes
    row_req(rcppm_pkg::ActionSetChannel, 4'd0, 16'd0, 1'b1, 3'b101);
    row_req(rcppm_pkg::ActionSetChannel, 4'd1, 16'd2, 1'b1, 3'b101);
    row_req(rcppm_pkg::ActionTick, 4'd0, 16'd0, 1'b1, 3'b110);
    for (int i = 0; i < 4; i++) row_req(rcppm_pkg::ActionTick, 4'd0, 16'd0, 1'b0, '0);
    // mid-frame change: applies from the next segment load
    row_cfg(rcppm_pkg::RegFrameLength, 16'd40);
    row_cfg(rcppm_pkg::RegInvertOutput, 16'd0);
    for (int i = 0; i < 5; i++) row_req(rcppm_pkg::ActionTick, 4'd0, 16'd0, 1'b0, '0);
    row_cfg(rcppm_pkg::RegMinValue, 16'd1000);
    row_cfg(rcppm_pkg::RegMaxValue, 16'd2000);
    row_req(rcppm_pkg::ActionSetChannel, 4'd3, 16'd999, 1'b0, '0);
    row_req(rcppm_pkg::ActionSetChannel, 4'd3, 16'd1000, 1'b0, '0);
    row_req(rcppm_pkg::ActionSetChannel, 4'd4, 16'd2000, 1'b0, '0);
    row_req(rcppm_pkg::ActionSetChannel, 4'd4, 16'd2001, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain();
        cfg_write(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        typed_rsp_q.push_back(stim_rows[i]);
        send_req(stim_rows[i].req);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      s.channel_count = 4'($urandom_range(0, 15));
      s.sync_width    = 16'($urandom_range(0, 4));
      s.frame_length  = 16'($urandom_range(0, 80));
      s.min_frame_gap = 16'($urandom_range(0, 8));
      s.invert_output = 1'($urandom_range(0, 1));
      s.min_value     = 16'($urandom_range(0, 6));
      s.max_value     = 16'($urandom_range(4, 20));
      case (ph)
        1: s.channel_count = 4'd0;
        2: begin
          s.channel_count = 4'd15;
          s.min_value     = 16'hFFFF;
          s.max_value     = 16'd0;
        end
        3: begin
          s.sync_width    = 16'd0;
          s.min_frame_gap = 16'd0;
          s.frame_length  = 16'd0;
        end
        4: s.channel_count = 4'd1;
        5: s.channel_count = 4'd10;
        6: s = '{channel_count: 4'd8, sync_width: 16'd300, frame_length: 16'd22500,
                 min_frame_gap: 16'd4000, invert_output: 1'b0,
                 min_value: 16'd1000, max_value: 16'd2000};
        NumPhases - 1: begin
          quiet = 1'b1;
          s = '{channel_count: 4'd10, sync_width: 16'hFFFF, frame_length: 16'hFFFF,
                min_frame_gap: 16'hFFFF, invert_output: 1'b1,
                min_value: 16'd0, max_value: 16'hFFFF};
        end
        default: ;
      endcase
      cfg_write(rcppm_pkg::RegChannelCount, rcppm_pkg::width_t'(s.channel_count));
      cfg_write(rcppm_pkg::RegSyncWidth, s.sync_width);
      cfg_write(rcppm_pkg::RegFrameLength, s.frame_length);
      cfg_write(rcppm_pkg::RegMinFrameGap, s.min_frame_gap);
      cfg_write(rcppm_pkg::RegInvertOutput, rcppm_pkg::width_t'(s.invert_output));
      cfg_write(rcppm_pkg::RegMinValue, s.min_value);
      cfg_write(rcppm_pkg::RegMaxValue, s.max_value);
      for (int i = 0; i < PhaseItems; i++) begin
        r.action  = ($urandom_range(0, 9) < 3) ? rcppm_pkg::ActionSetChannel
                                                : rcppm_pkg::ActionTick;
        r.channel = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 4) == 0) r.width_value = 16'($urandom());
        else                           r.width_value = 16'($urandom_range(0, 24));
        send_req(r);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $error("%0d predicted results never arrived", pending_rsp.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- rc_ppm_frame_generator.f -----
rtl/core/rcppm_pkg.sv
rtl/core/rcppm_cfg_regs.sv
rtl/core/rcppm_seg_pick.sv
rtl/core/rcppm_engine.sv
rtl/core/rc_ppm_frame_generator.sv
rtl/core/rcppm_checker.sv
dv/tb.sv
